@@ sv/cycle_time_average_monitor_assert.svh @@
// ----------------------------------------------------------------------------
// Cycle time average monitor: assertion macros
// Shared property shorthands for the monitor's checkers.
// ----------------------------------------------------------------------------
`ifndef CYCLE_TIME_AVERAGE_MONITOR_ASSERT_SVH
`define CYCLE_TIME_AVERAGE_MONITOR_ASSERT_SVH

// same-cycle implication
`define CTAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cycle_time_average_monitor: same-cycle check failed");

// next-cycle implication
`define CTAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cycle_time_average_monitor: next-cycle check failed");

`endif

@@ sv/ctam_pkg.sv @@
// ----------------------------------------------------------------------------
// Cycle time average monitor: package
// Widths, command codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package ctam_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned IVL_W     = CFG_W + 2;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned MAX_ENTRIES_DEF = 21;
  localparam int unsigned MIN_ENTRIES     = 10;

  localparam logic [CMD_W-1:0] CMD_START    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DONE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERR_LINE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_TIME = 1'd1;

endpackage

@@ sv/ctam_ram.sv @@
// ----------------------------------------------------------------------------
// Cycle time average monitor: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ctam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/ctam_div.sv @@
// ----------------------------------------------------------------------------
// Cycle time average monitor: serial divider
// Restoring unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctam_div #(
  parameter int unsigned DVD_W = 27,
  parameter int unsigned DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              q_bit;

  always_comb begin
    shifted  = {rem_r, quo_r[DVD_W-1]};
    q_bit    = (shifted >= {1'b0, dvs_r});
    diff     = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DVD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = q_bit ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], q_bit};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/cycle_time_average_monitor.sv @@
// ----------------------------------------------------------------------------
// Cycle time average monitor
// Moving average of machine cycle intervals with a sticky threshold flag.
// ----------------------------------------------------------------------------
// Each request (start, cycle done, error-line change or unused code)
// produces exactly one result. A request passes from acceptance through the
// ring read, the update and write-back, the serial divider that forms the
// average one sum bit at a time, and the load of the result register. The
// next request is taken once the previous one has reached the result
// register, even while that result still waits for out_ready. The interval
// history lives in a MAX_ENTRIES deep RAM used as a ring; only held entries
// are used, so it needs no clearing after reset.
// ----------------------------------------------------------------------------
module cycle_time_average_monitor #(
  parameter int unsigned MAX_ENTRIES = ctam_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctam_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ctam_pkg::CMD_W-1:0]     in_cmd,
  input  logic [ctam_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                           in_error_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_interval_accepted,
  output logic                           out_average_valid,
  output logic [ctam_pkg::IVL_W-1:0]     out_average_ms,
  output logic                           out_error_flag
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W = ctam_pkg::IVL_W + CNT_W;
  localparam int unsigned IVL_W = ctam_pkg::IVL_W;
  localparam int unsigned TIME_W = ctam_pkg::TIME_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [ctam_pkg::CFG_W-1:0]     cyc_time_r, err_time_r;
  logic [ctam_pkg::CMD_W-1:0]     cmd_r;
  logic [TIME_W-1:0]              now_r;
  logic                           level_r;
  logic [TIME_W-1:0]              last_r, last_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [IDX_W-1:0]               oldest_r, oldest_nxt;
  logic [SUM_W-1:0]               sum_r, sum_nxt;
  logic                           latch_r, latch_nxt;
  logic                           acc_r, acc_nxt;
  logic                           res_avg_vld_r, res_avg_vld_nxt;
  logic [IVL_W-1:0]               res_avg_r, res_avg_nxt;

  logic                           out_valid_r;
  logic                           out_acc_r;
  logic                           out_avg_vld_r;
  logic [IVL_W-1:0]               out_avg_r;
  logic                           out_err_r;
  logic                           out_load;

  logic [TIME_W-1:0]              diff;
  logic [IVL_W-1:0]               limit;
  logic                           take;
  logic                           full;
  logic [CNT_W:0]                 wr_pos;
  logic [IDX_W:0]                 oldest_inc;
  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [IVL_W-1:0]               ram_rdata;
  logic                           div_start;
  logic                           div_done;
  logic [SUM_W-1:0]               div_quo;
  logic                           avg_vld;

  ctam_ram #(
    .WIDTH (IVL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (diff[IVL_W-1:0]),
    .rd_en   (in_valid && in_ready),
    .rd_addr (oldest_r),
    .rd_data (ram_rdata)
  );

  ctam_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (cnt_nxt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_RES) && (!out_valid_r || out_ready);

  always_comb begin
    diff       = now_r - last_r;
    limit      = {2'b00, cyc_time_r} + {1'b0, cyc_time_r, 1'b0};
    take       = (cmd_r == ctam_pkg::CMD_DONE) && (diff < TIME_W'(limit));
    full       = (cnt_r == CNT_W'(MAX_ENTRIES));
    wr_pos     = (CNT_W+1)'(oldest_r) + (CNT_W+1)'(cnt_r);
    if (wr_pos >= (CNT_W+1)'(MAX_ENTRIES)) begin
      wr_pos = wr_pos - (CNT_W+1)'(MAX_ENTRIES);
    end
    oldest_inc = (IDX_W+1)'(oldest_r) + 1'b1;
    if (oldest_inc == (IDX_W+1)'(MAX_ENTRIES)) begin
      oldest_inc = '0;
    end
    ram_waddr  = full ? oldest_r : wr_pos[IDX_W-1:0];
    avg_vld    = (32'(cnt_r) >= ctam_pkg::MIN_ENTRIES) && (cnt_r != '0);

    state_nxt       = state_r;
    last_nxt        = last_r;
    cnt_nxt         = cnt_r;
    oldest_nxt      = oldest_r;
    sum_nxt         = sum_r;
    latch_nxt       = latch_r;
    acc_nxt         = acc_r;
    res_avg_vld_nxt = res_avg_vld_r;
    res_avg_nxt     = res_avg_r;
    ram_we          = 1'b0;
    div_start       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        acc_nxt   = take;
        div_start = 1'b1;
        state_nxt = ST_DIV;
        case (cmd_r)
          ctam_pkg::CMD_START: begin
            last_nxt = now_r;
          end
          ctam_pkg::CMD_DONE: begin
            last_nxt = now_r;
            if (take) begin
              ram_we  = 1'b1;
              sum_nxt = sum_r + SUM_W'(diff[IVL_W-1:0])
                        - (full ? SUM_W'(ram_rdata) : SUM_W'(0));
              if (full) begin
                oldest_nxt = oldest_inc[IDX_W-1:0];
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
          end
          ctam_pkg::CMD_ERR_LINE: begin
            latch_nxt = level_r;
            if (!level_r) begin
              cnt_nxt    = '0;
              oldest_nxt = '0;
              sum_nxt    = '0;
            end
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          res_avg_vld_nxt = avg_vld;
          res_avg_nxt     = avg_vld ? div_quo[IVL_W-1:0] : '0;
          if (avg_vld && (cmd_r == ctam_pkg::CMD_DONE)
              && (div_quo > SUM_W'(err_time_r))) begin
            latch_nxt = 1'b1;
          end
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cyc_time_r  <= '0;
      err_time_r  <= '0;
      last_r      <= '0;
      cnt_r       <= '0;
      oldest_r    <= '0;
      sum_r       <= '0;
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      last_r   <= last_nxt;
      cnt_r    <= cnt_nxt;
      oldest_r <= oldest_nxt;
      sum_r    <= sum_nxt;
      latch_r  <= latch_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          ctam_pkg::CFG_CYCLE_TIME: cyc_time_r <= cfg_data;
          ctam_pkg::CFG_ERROR_TIME: err_time_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      cmd_r   <= in_cmd;
      now_r   <= in_now_ms;
      level_r <= in_error_level;
    end
    acc_r         <= acc_nxt;
    res_avg_vld_r <= res_avg_vld_nxt;
    res_avg_r     <= res_avg_nxt;
    if (out_load) begin
      out_acc_r     <= acc_r;
      out_avg_vld_r <= res_avg_vld_r;
      out_avg_r     <= res_avg_r;
      out_err_r     <= latch_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_interval_accepted = out_acc_r;
  assign out_average_valid     = out_avg_vld_r;
  assign out_average_ms        = out_avg_r;
  assign out_error_flag        = out_err_r;

endmodule

@@ sv/ctam_checker.sv @@
// ----------------------------------------------------------------------------
// Cycle time average monitor: port checker
// Port-level checks, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "cycle_time_average_monitor_assert.svh"

module ctam_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [ctam_pkg::CMD_W-1:0] in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_interval_accepted,
  input logic                       out_average_valid,
  input logic [ctam_pkg::IVL_W-1:0] out_average_ms,
  input logic                       out_error_flag
);

  // a waiting result holds
  `CTAM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_interval_accepted) && $stable(out_average_valid) && $stable(out_average_ms) && $stable(out_error_flag))

  // one request at a time
  `CTAM_ASSERT_NXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready)

  // no average without enough history
  `CTAM_ASSERT_IMP(a_avg_zero, clk, rst_n, out_valid && !out_average_valid, out_average_ms == '0)

  // a fresh cycle-done request never finishes in the very next cycle
  `CTAM_ASSERT_NXT(a_min_latency, clk, rst_n, in_valid && in_ready && in_cmd == ctam_pkg::CMD_DONE, !(out_valid && !$past(out_valid)))

endmodule

bind cycle_time_average_monitor ctam_checker u_ctam_checker (.*);

@@ tb/cycle_time_average_monitor_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cycle time average monitor: testbench
// Drives start, cycle-done, error-line and unused requests through the
// request channel under random idling on both sides. A scoreboard keeps its
// own interval history and predicts each result for field-by-field checking.
// ----------------------------------------------------------------------------
module cycle_time_average_monitor_test;
  import ctam_pkg::*;

  localparam int unsigned HISTORY_DEPTH = MAX_ENTRIES_DEF;
  localparam int unsigned SUM_W = 27;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};

  typedef struct packed {
    logic             interval_accepted;
    logic             average_valid;
    logic [IVL_W-1:0] average_ms;
    logic             error_flag;
  } cycle_report_t;

  class cycle_average_scoreboard;
    logic [CFG_W-1:0]  cycle_time_ms;
    logic [CFG_W-1:0]  error_time_ms;
    logic [TIME_W-1:0] last_stamp;
    logic [IVL_W-1:0]  interval_ring [HISTORY_DEPTH];
    int unsigned       held;
    int unsigned       oldest;
    logic [SUM_W-1:0]  interval_sum;
    logic              error_latch;
    cycle_report_t     expected_reports [$];
    int unsigned       mismatch_count;

    function new();
      cycle_time_ms  = '0;
      error_time_ms  = '0;
      last_stamp     = '0;
      held           = 0;
      oldest         = 0;
      interval_sum   = '0;
      error_latch    = 1'b0;
      mismatch_count = 0;
    endfunction

    function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_CYCLE_TIME) cycle_time_ms = data;
      else if (idx == CFG_ERROR_TIME) error_time_ms = data;
    endfunction

    function void clear_history();
      held         = 0;
      oldest       = 0;
      interval_sum = '0;
    endfunction

    function void store_interval(logic [IVL_W-1:0] ivl);
      if (held >= HISTORY_DEPTH) begin
        interval_sum = interval_sum - SUM_W'(interval_ring[oldest]);
        oldest = (oldest + 1) % HISTORY_DEPTH;
        held--;
      end
      interval_ring[(oldest + held) % HISTORY_DEPTH] = ivl;
      interval_sum = interval_sum + SUM_W'(ivl);
      held++;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now,
                               logic level);
      cycle_report_t     want;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] limit;
      want = '0;
      case (cmd)
        CMD_START: last_stamp = now;
        CMD_DONE: begin
          gap   = now - last_stamp;
          limit = TIME_W'(cycle_time_ms) * 32'd3;
          if (gap < limit) begin
            store_interval(IVL_W'(gap));
            want.interval_accepted = 1'b1;
          end
        end
        CMD_ERR_LINE: begin
          error_latch = level;
          if (!level) clear_history();
        end
        default: ;
      endcase
      if (held >= MIN_ENTRIES && held > 0) begin
        want.average_valid = 1'b1;
        want.average_ms = IVL_W'(interval_sum / held);
        if (cmd == CMD_DONE && want.average_ms > error_time_ms) error_latch = 1'b1;
      end
      if (cmd == CMD_DONE) last_stamp = now;
      want.error_flag = error_latch;
      expected_reports.push_back(want);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    task check_result(cycle_report_t got);
      cycle_report_t want;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("result with no request pending (avg %0d)",
                                  got.average_ms));
        return;
      end
      want = expected_reports.pop_front();
      if (got.interval_accepted !== want.interval_accepted ||
          got.average_valid !== want.average_valid ||
          got.average_ms !== want.average_ms ||
          got.error_flag !== want.error_flag)
        report_mismatch($sformatf(
          "acc %b/%b valid %b/%b avg %0d/%0d flag %b/%b (got/exp)",
          got.interval_accepted, want.interval_accepted,
          got.average_valid, want.average_valid,
          got.average_ms, want.average_ms,
          got.error_flag, want.error_flag));
    endtask

    function int unsigned pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CYCLE_TIME;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_cmd = CMD_START;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 in_error_level = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_interval_accepted;
  logic                 out_average_valid;
  logic [IVL_W-1:0]     out_average_ms;
  logic                 out_error_flag;

  logic        steady = 1'b0;
  int unsigned hold_left = 0;

  cycle_average_scoreboard sb = new();

  cycle_time_average_monitor dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_cmd                (in_cmd),
    .in_now_ms             (in_now_ms),
    .in_error_level        (in_error_level),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_interval_accepted (out_interval_accepted),
    .out_average_valid     (out_average_valid),
    .out_average_ms        (out_average_ms),
    .out_error_flag        (out_error_flag)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_config(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_request(in_cmd, in_now_ms, in_error_level);
      if (out_valid && out_ready)
        sb.check_result('{out_interval_accepted, out_average_valid,
                          out_average_ms, out_error_flag});
    end
  end

  // receiver: short random stalls plus occasional long holds
  always @(negedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 1) begin
      hold_left <= $urandom_range(4, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                              input logic level);
    if (!steady && $urandom_range(0, 99) < 30)
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(4, 36))
        @(negedge clk);
    in_valid       = 1'b1;
    in_cmd         = cmd;
    in_now_ms      = now;
    in_error_level = level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic int unsigned pick_interval(int unsigned lim, int unsigned ct);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (lim == 0) return $urandom_range(0, 500);
    if (k < 40) return $urandom_range(0, lim - 1);
    if (k < 75) return $urandom_range(ct - ct / 4, ct + ct / 4);
    if (k < 83) return lim - 1;
    if (k < 88) return lim;
    return $urandom_range(lim + 1, 2 * lim + 1);
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] ct, input logic [CFG_W-1:0] et,
                           input int unsigned count);
    int unsigned       lim;
    int unsigned       pick;
    logic [TIME_W-1:0] stamp;
    write_register(CFG_CYCLE_TIME, ct);
    write_register(CFG_ERROR_TIME, et);
    lim = 3 * ct;
    // start some sequences just below the timestamp wrap
    if ($urandom_range(0, 3) == 0) stamp = 32'hFFFF_FFFF - $urandom_range(0, 20 * lim + 20);
    else stamp = $urandom;
    send_request(CMD_START, stamp, 1'b0);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        if ($urandom_range(0, 1)) stamp = $urandom;
        send_request(CMD_START, stamp, 1'($urandom_range(0, 1)));
      end else if (pick < 84) begin
        stamp = stamp + pick_interval(lim, 32'(ct));
        send_request(CMD_DONE, stamp, 1'($urandom_range(0, 1)));
      end else if (pick < 89) begin
        send_request(CMD_ERR_LINE, $urandom, 1'b1);
      end else if (pick < 91) begin
        send_request(CMD_ERR_LINE, $urandom, 1'b0);
      end else if (pick < 94) begin
        send_request(CMD_UNUSED, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        send_request(CMD_DONE, $urandom, 1'($urandom_range(0, 1)));
      end
    end
    wait_drained();
  endtask

  initial begin
    #8_000_000;
    $display("** cycle_time_average_monitor: FAILED **");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] stamp;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero cycle time after reset: nothing is ever stored
    send_request(CMD_DONE, 32'd5, 1'b0);
    send_request(CMD_START, 32'd0, 1'b0);
    send_request(CMD_DONE, 32'd0, 1'b0);
    send_request(CMD_ERR_LINE, 32'd0, 1'b1);
    send_request(CMD_ERR_LINE, 32'd0, 1'b0);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // largest cycle time, zero error time
    write_register(CFG_CYCLE_TIME, CFG_MAX);
    write_register(CFG_ERROR_TIME, '0);
    stamp = 32'hFFFF_FFF0;
    send_request(CMD_START, stamp, 1'b0);
    stamp = 32'h0000_0010;
    send_request(CMD_DONE, stamp, 1'b0);
    stamp = stamp + 32'd3145725;
    send_request(CMD_DONE, stamp, 1'b0);
    for (int i = 0; i < 11; i++) begin
      stamp = stamp + 32'd3145724;
      send_request(CMD_DONE, stamp, 1'b1);
    end
    send_request(CMD_DONE, stamp, 1'b0);
    send_request(CMD_ERR_LINE, stamp, 1'b1);
    send_request(CMD_ERR_LINE, stamp, 1'b0);
    send_request(CMD_DONE, stamp + 32'd1, 1'b0);
    wait_drained();

    run_phase(20'd100, 20'd150, 150);
    run_phase(20'd1, 20'd0, 150);
    steady = 1'b1;
    run_phase(20'd1000, 20'd900, 200);
    steady = 1'b0;
    run_phase(CFG_MAX, CFG_MAX, 150);
    run_phase(CFG_MAX, 20'd0, 100);
    run_phase(20'd0, 20'd5, 100);
    run_phase(20'd50, 20'd60, 150);
    run_phase(CFG_W'($urandom_range(0, 1048575)), CFG_W'($urandom_range(0, 1048575)), 150);
    run_phase(20'd20000, 20'd25000, 100);

    wait_drained();
    repeat (64) @(negedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("** cycle_time_average_monitor: PASSED **");
    else
      $display("** cycle_time_average_monitor: FAILED **");
    $finish;
  end

endmodule
